// File: design/cursor_pan_and_position_assert.svh
// Assertion macros for the cursor pan and position block.
`ifndef CURSOR_PAN_AND_POSITION_ASSERT_SVH
`define CURSOR_PAN_AND_POSITION_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define CPP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cursor_pan_and_position: assertion failed");

// Next-cycle implication, disabled while in reset.
`define CPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cursor_pan_and_position: assertion failed");

`endif

// File: design/cpp_pkg.sv
// Shared types, constants and helpers for the cursor pan and position block.
`default_nettype none

package cpp_pkg;

    localparam int CURSOR_SIZE    = 16;
    localparam int CURSOR_AREA    = 64;
    localparam int PAN_ALIGN_MASK = 7;

    localparam int POS_W  = 12;
    localparam int SIZE_W = 13;
    localparam int HOT_W  = 4;
    localparam int BASE_W = 24;
    localparam int ADDR_W = 25;
    localparam int SKIP_W = 6;
    localparam int CLIP_W = 4;
    localparam int IN_W   = 16;
    localparam int IDX_W  = 3;

    localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(4096);
    localparam logic [SIZE_W-1:0] ALIGN_MASK = SIZE_W'(PAN_ALIGN_MASK);
    localparam logic [SKIP_W-1:0] SKIP_BASE  = SKIP_W'(CURSOR_AREA - CURSOR_SIZE);
    localparam logic [CLIP_W-1:0] CLIP_MAX   = CLIP_W'(CURSOR_SIZE - 1);

    typedef enum logic [IDX_W-1:0] {
        REG_DESK_WIDTH     = 3'd0,
        REG_DESK_HEIGHT    = 3'd1,
        REG_VISIBLE_WIDTH  = 3'd2,
        REG_VISIBLE_HEIGHT = 3'd3,
        REG_HOTSPOT_X      = 3'd4,
        REG_HOTSPOT_Y      = 3'd5,
        REG_CURSOR_SHOWN   = 3'd6,
        REG_IMAGE_BASE     = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [SIZE_W-1:0] desk_width;
        logic [SIZE_W-1:0] desk_height;
        logic [SIZE_W-1:0] visible_width;
        logic [SIZE_W-1:0] visible_height;
        logic [HOT_W-1:0]  hotspot_x;
        logic [HOT_W-1:0]  hotspot_y;
        logic              cursor_shown;
        logic [BASE_W-1:0] image_base_qwords;
    } cfg_t;

    typedef struct packed {
        logic              pan_request;
        logic [POS_W-1:0]  origin_x;
        logic [POS_W-1:0]  origin_y;
        logic [POS_W-1:0]  cursor_col;
        logic [POS_W-1:0]  cursor_row;
        logic [SKIP_W-1:0] image_skip_x;
        logic [SKIP_W-1:0] image_skip_y;
        logic [ADDR_W-1:0] image_address;
    } result_t;

    // Treat a zero size as one pixel and cap it at 4096.
    function automatic logic [SIZE_W-1:0] size_of(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] s;
        s = v;
        if (v == '0)
        begin
            s = SIZE_W'(1);
        end
        else if (v > SIZE_MAX)
        begin
            s = SIZE_MAX;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// File: design/cursor_pan_and_position.sv
// Top level of the cursor pan and position block.
// Each pointer item is clamped to the virtual desktop, the window origin is panned
// when the pointer leaves it (and kept only while the cursor is shown), and the
// cursor position, image skips and image address come out as one result item.
// An item waits in the input register and is then moved into the result register
// when that is free; the stored window origin is updated on that same edge, so a
// new item is taken every cycle unless out_ready back-pressure stalls the result
// register, and out_valid rises as the item enters it. Configuration writes are
// always ready and take effect on the next edge; write them only while no item is
// in flight.
`default_nettype none

`include "cursor_pan_and_position_assert.svh"

module cursor_pan_and_position (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [cpp_pkg::IDX_W-1:0]       cfg_index,
    input  wire logic [cpp_pkg::BASE_W-1:0]      cfg_data,

    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [cpp_pkg::IN_W-1:0]        pointer_x,
    input  wire logic [cpp_pkg::IN_W-1:0]        pointer_y,

    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 pan_request,
    output logic [cpp_pkg::POS_W-1:0]            origin_x,
    output logic [cpp_pkg::POS_W-1:0]            origin_y,
    output logic [cpp_pkg::POS_W-1:0]            cursor_col,
    output logic [cpp_pkg::POS_W-1:0]            cursor_row,
    output logic [cpp_pkg::SKIP_W-1:0]           image_skip_x,
    output logic [cpp_pkg::SKIP_W-1:0]           image_skip_y,
    output logic [cpp_pkg::ADDR_W-1:0]           image_address
);

    cpp_pkg::cfg_t              cfg_reg;
    logic [cpp_pkg::POS_W-1:0]  win_x_reg, win_y_reg;
    logic                       in_valid_reg;
    logic [cpp_pkg::IN_W-1:0]   px_reg, py_reg;
    logic                       out_valid_reg;
    cpp_pkg::result_t           res_reg, res_next;
    logic                       xfer;
    cpp_pkg::cfg_reg_t          cfg_sel;

    assign cfg_ready = 1'b1;
    assign cfg_sel   = cpp_pkg::cfg_reg_t'(cfg_index);
    assign xfer      = in_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready  = ~in_valid_reg | xfer;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.desk_width        <= cpp_pkg::SIZE_W'(1024);
            cfg_reg.desk_height       <= cpp_pkg::SIZE_W'(768);
            cfg_reg.visible_width     <= cpp_pkg::SIZE_W'(1024);
            cfg_reg.visible_height    <= cpp_pkg::SIZE_W'(768);
            cfg_reg.hotspot_x         <= '0;
            cfg_reg.hotspot_y         <= '0;
            cfg_reg.cursor_shown      <= 1'b0;
            cfg_reg.image_base_qwords <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_sel)
                cpp_pkg::REG_DESK_WIDTH:
                    cfg_reg.desk_width     <= cfg_data[cpp_pkg::SIZE_W-1:0];
                cpp_pkg::REG_DESK_HEIGHT:
                    cfg_reg.desk_height    <= cfg_data[cpp_pkg::SIZE_W-1:0];
                cpp_pkg::REG_VISIBLE_WIDTH:
                    cfg_reg.visible_width  <= cfg_data[cpp_pkg::SIZE_W-1:0];
                cpp_pkg::REG_VISIBLE_HEIGHT:
                    cfg_reg.visible_height <= cfg_data[cpp_pkg::SIZE_W-1:0];
                cpp_pkg::REG_HOTSPOT_X:
                    cfg_reg.hotspot_x      <= cfg_data[cpp_pkg::HOT_W-1:0];
                cpp_pkg::REG_HOTSPOT_Y:
                    cfg_reg.hotspot_y      <= cfg_data[cpp_pkg::HOT_W-1:0];
                cpp_pkg::REG_CURSOR_SHOWN:
                    cfg_reg.cursor_shown   <= cfg_data[0];
                cpp_pkg::REG_IMAGE_BASE:
                    cfg_reg.image_base_qwords <= cfg_data;
                default:
                    cfg_reg.cursor_shown   <= cfg_reg.cursor_shown;
            endcase
        end
    end

    cpp_calc u_calc (
        .cfg   (cfg_reg),
        .win_x (win_x_reg),
        .win_y (win_y_reg),
        .px    (px_reg),
        .py    (py_reg),
        .res   (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            win_x_reg     <= '0;
            win_y_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (xfer)
            begin
                out_valid_reg <= 1'b1;
                if (cfg_reg.cursor_shown)
                begin
                    win_x_reg <= res_next.origin_x;
                    win_y_reg <= res_next.origin_y;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: hold until the next item moves in.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            px_reg <= pointer_x;
            py_reg <= pointer_y;
        end
        if (xfer)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pan_request   = res_reg.pan_request;
    assign origin_x      = res_reg.origin_x;
    assign origin_y      = res_reg.origin_y;
    assign cursor_col    = res_reg.cursor_col;
    assign cursor_row    = res_reg.cursor_row;
    assign image_skip_x  = res_reg.image_skip_x;
    assign image_skip_y  = res_reg.image_skip_y;
    assign image_address = res_reg.image_address;

    `CPP_ASSERT_NEXT(a_origin_hold, clk, rst_n, !(xfer && cfg_reg.cursor_shown), $stable(win_x_reg) && $stable(win_y_reg))
    `CPP_ASSERT_NEXT(a_xfer_shows, clk, rst_n, xfer, out_valid_reg && (res_reg == $past(res_next)))
    `CPP_ASSERT_SAME(a_result_form, clk, rst_n, out_valid_reg, (res_reg.origin_x[2:0] == 3'b000) && (res_reg.image_skip_x[5:4] == 2'b11) && (res_reg.image_skip_y[5:4] == 2'b11))

endmodule

`default_nettype wire

// File: design/cpp_calc.sv
// Clamp, pan and cursor placement logic for one pointer item.
`default_nettype none

module cpp_calc (
    input  wire cpp_pkg::cfg_t                   cfg,
    input  wire logic [cpp_pkg::POS_W-1:0]       win_x,
    input  wire logic [cpp_pkg::POS_W-1:0]       win_y,
    input  wire logic [cpp_pkg::IN_W-1:0]        px,
    input  wire logic [cpp_pkg::IN_W-1:0]        py,
    output cpp_pkg::result_t                     res
);

    localparam int W14 = cpp_pkg::SIZE_W + 1;

    logic [cpp_pkg::SIZE_W-1:0] vw, vh, sw, sh;
    logic [cpp_pkg::POS_W-1:0]  xc, yc;
    logic [cpp_pkg::POS_W-1:0]  ox, oy;
    logic                       move;
    logic [W14-1:0]             up_x;
    logic [cpp_pkg::SIZE_W-1:0] al_x;
    logic [W14-1:0]             cx, cy, mx, my;
    logic [cpp_pkg::CLIP_W-1:0] dx, dy;
    logic [cpp_pkg::POS_W-1:0]  col, row;

    always_comb
    begin
        vw = cpp_pkg::size_of(cfg.desk_width);
        vh = cpp_pkg::size_of(cfg.desk_height);
        sw = cpp_pkg::size_of(cfg.visible_width);
        sh = cpp_pkg::size_of(cfg.visible_height);

        if (px >= {3'b000, vw})
        begin
            xc = cpp_pkg::POS_W'(vw - 1'b1);
        end
        else
        begin
            xc = px[cpp_pkg::POS_W-1:0];
        end
        if (py >= {3'b000, vh})
        begin
            yc = cpp_pkg::POS_W'(vh - 1'b1);
        end
        else
        begin
            yc = py[cpp_pkg::POS_W-1:0];
        end

        move = 1'b0;
        ox   = win_x;
        oy   = win_y;
        up_x = {2'b00, xc} - {1'b0, sw} + W14'(1) + W14'(cpp_pkg::PAN_ALIGN_MASK);
        al_x = up_x[cpp_pkg::SIZE_W-1:0] & ~cpp_pkg::ALIGN_MASK;

        priority if ({2'b00, xc} >= ({1'b0, sw} + {2'b00, win_x}))
        begin
            move = 1'b1;
            if (al_x[cpp_pkg::SIZE_W-1])
            begin
                ox = {cpp_pkg::POS_W{1'b1}} & ~cpp_pkg::ALIGN_MASK[cpp_pkg::POS_W-1:0];
            end
            else
            begin
                ox = al_x[cpp_pkg::POS_W-1:0];
            end
        end
        else if (xc < win_x)
        begin
            move = 1'b1;
            ox   = xc & ~cpp_pkg::ALIGN_MASK[cpp_pkg::POS_W-1:0];
        end
        else
        begin
            ox   = win_x;
        end

        priority if ({1'b0, yc} >= (sh + {1'b0, win_y}))
        begin
            move = 1'b1;
            oy   = cpp_pkg::POS_W'({1'b0, yc} - sh + 1'b1);
        end
        else if (yc < win_y)
        begin
            move = 1'b1;
            oy   = yc;
        end
        else
        begin
            oy   = win_y;
        end

        cx = {2'b00, xc} - {2'b00, ox} - W14'(cfg.hotspot_x);
        cy = {2'b00, yc} - {2'b00, oy} - W14'(cfg.hotspot_y);
        mx = -cx;
        my = -cy;

        if (cx[W14-1])
        begin
            col = '0;
            dx  = (mx > W14'(cpp_pkg::CLIP_MAX)) ? cpp_pkg::CLIP_MAX : mx[cpp_pkg::CLIP_W-1:0];
        end
        else
        begin
            col = cx[cpp_pkg::POS_W-1:0];
            dx  = '0;
        end
        if (cy[W14-1])
        begin
            row = '0;
            dy  = (my > W14'(cpp_pkg::CLIP_MAX)) ? cpp_pkg::CLIP_MAX : my[cpp_pkg::CLIP_W-1:0];
        end
        else
        begin
            row = cy[cpp_pkg::POS_W-1:0];
            dy  = '0;
        end

        res.pan_request   = move & cfg.cursor_shown;
        res.origin_x      = ox;
        res.origin_y      = oy;
        res.cursor_col    = col;
        res.cursor_row    = row;
        res.image_skip_x  = cpp_pkg::SKIP_BASE + cpp_pkg::SKIP_W'(dx);
        res.image_skip_y  = cpp_pkg::SKIP_BASE + cpp_pkg::SKIP_W'(dy);
        res.image_address = {1'b0, cfg.image_base_qwords}
                          + cpp_pkg::ADDR_W'({dy, 1'b0});
    end

endmodule

`default_nettype wire
